/* src/mfdq_pkg.sv */
`timescale 1ns / 1ps

package mfdq_pkg;

  // motion queue
  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // serial frame format
  localparam int         FRAME_LEN    = 10;
  localparam int         FPOS_W       = $clog2(FRAME_LEN);
  localparam int         PAYLOAD_LEN  = 7;   // bytes 2..8 of a frame
  localparam int         PIDX_W       = $clog2(PAYLOAD_LEN);
  localparam logic [7:0] START_BYTE   = 8'hAA;
  localparam logic [7:0] FRAME_OPCODE = 8'h01;

  // short move packet
  localparam logic [7:0] PKT_REPORT   = 8'h10;
  localparam logic [7:0] PKT_FEATURE  = 8'hFE;
  localparam logic [6:0] MOVE_MIN_LEN = 7'd7;

  typedef enum logic [1:0] {
    OP_BYTE     = 2'd0,
    OP_LINE_ERR = 2'd1,
    OP_PACKET   = 2'd2,
    OP_SERVICE  = 2'd3
  } op_t;

  localparam logic [1:0] SEND_OK   = 2'd0;
  localparam logic [1:0] SEND_BUSY = 2'd1;

  localparam logic [7:0] ST_FRAME_OK  = 8'h01;
  localparam logic [7:0] ST_QUEUED    = 8'h02;
  localparam logic [7:0] ST_DROPPED   = 8'h04;
  localparam logic [7:0] ST_SENT      = 8'h08;
  localparam logic [7:0] ST_BUSY      = 8'h10;
  localparam logic [7:0] ST_FAIL      = 8'h20;
  localparam logic [7:0] ST_CHECK_ERR = 8'h40;
  localparam logic [7:0] ST_OVERRUN   = 8'h80;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // result buffer; depth must be a power of two
  localparam int MAX_RESULTS = 3;
  localparam int NRES_W      = 2;
  localparam int OUT_DEPTH   = 4;
  localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic [7:0]         buttons;
    logic signed [7:0]  wheel;
    logic signed [7:0]  pan;
    logic [7:0]         status;
  } entry_t;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic [7:0]         buttons;
    logic signed [7:0]  wheel;
    logic signed [7:0]  pan;
    logic [7:0]         status;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [NRES_W-1:0]              n;
    result_t [MAX_RESULTS-1:0]      beats;
  } push_t;

endpackage

/* src/mouse_frame_deframer_queue.sv */
`timescale 1ns / 1ps
// Results of an accepted item are written into the result buffer in the next cycle.
// Throughput: one item per cycle; the 4-deep result buffer takes an item while it
//   holds at most one undelivered result, and drains one result beat per cycle while result_ready is high.
// Reset (synchronous): deframer hunts for a start byte, motion queue and result
//   buffer are empty, pending error status is clear. No clearing pass.

module mouse_frame_deframer_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic [1:0]         operation,
  input  logic [7:0]         rx_byte,
  input  logic [6:0]         packet_length,
  input  logic [7:0]         report_byte,
  input  logic [7:0]         feature_byte,
  input  logic signed [15:0] move_dx,
  input  logic signed [15:0] move_dy,
  input  logic               endpoint_ready,
  input  logic [1:0]         send_code,
  output logic               result_valid,
  input  logic               result_ready,
  output logic               result_kind,
  output logic signed [15:0] report_dx,
  output logic signed [15:0] report_dy,
  output logic [7:0]         report_buttons,
  output logic signed [7:0]  report_wheel,
  output logic signed [7:0]  report_pan,
  output logic [7:0]         status_byte,
  output logic               last_of_run
);

  // deframer state
  logic                         in_frame;
  logic [mfdq_pkg::FPOS_W-1:0]  byte_position;
  logic [7:0]                   xor_acc;
  logic                         opcode_ok;
  logic [7:0]                   frame_bytes [mfdq_pkg::PAYLOAD_LEN];

  // motion queue
  mfdq_pkg::entry_t             queue_entries [mfdq_pkg::QUEUE_DEPTH];
  logic [mfdq_pkg::QPTR_W-1:0]  queue_head;
  logic [mfdq_pkg::QPTR_W-1:0]  queue_tail;
  logic [mfdq_pkg::QCNT_W-1:0]  queue_count;
  logic [7:0]                   pending_error;
  logic [7:0]                   pending_error_next;
  logic                         status_already_sent;

  logic                         accept;
  mfdq_pkg::op_t                op;
  logic                         space_ok;
  logic                         queue_full;
  logic                         frame_end;
  logic                         frame_good;
  logic                         push_frame;
  logic                         push_pkt;
  logic                         push;
  logic                         pop;
  logic                         have_rep;
  logic                         send_status;
  logic                         flush_err;
  logic [mfdq_pkg::FPOS_W-1:0]  pidx_wide;
  logic [mfdq_pkg::PIDX_W-1:0]  pidx;
  logic [7:0]                   send_bit;
  mfdq_pkg::entry_t             head_entry;
  mfdq_pkg::entry_t             new_entry;
  mfdq_pkg::result_t            rep_res;
  mfdq_pkg::result_t            stat_res;
  mfdq_pkg::result_t            err_res;
  mfdq_pkg::push_t              push_bus;
  mfdq_pkg::result_t            out_res;

  assign accept     = item_valid && item_ready;
  assign item_ready = space_ok;
  assign op         = mfdq_pkg::op_t'(operation);
  assign queue_full = queue_count >= mfdq_pkg::QCNT_W'(mfdq_pkg::QUEUE_DEPTH);
  assign head_entry = queue_entries[queue_head];

  // frame payload index: position 2 maps to slot 0
  assign pidx_wide = byte_position - mfdq_pkg::FPOS_W'(2);
  assign pidx      = pidx_wide[mfdq_pkg::PIDX_W-1:0];

  assign frame_end  = accept && (op == mfdq_pkg::OP_BYTE) && in_frame &&
                      (byte_position == mfdq_pkg::FPOS_W'(mfdq_pkg::FRAME_LEN - 1));
  assign frame_good = (xor_acc == rx_byte) && opcode_ok;
  assign push_frame = frame_end && frame_good && !queue_full;
  assign push_pkt   = accept && (op == mfdq_pkg::OP_PACKET) &&
                      (packet_length >= mfdq_pkg::MOVE_MIN_LEN) &&
                      (report_byte == mfdq_pkg::PKT_REPORT) &&
                      (feature_byte == mfdq_pkg::PKT_FEATURE) && !queue_full;
  assign push       = push_frame || push_pkt;

  assign have_rep    = accept && (op == mfdq_pkg::OP_SERVICE) && endpoint_ready &&
                       (queue_count != '0);
  assign send_status = have_rep && !status_already_sent;
  assign flush_err   = accept && (op == mfdq_pkg::OP_SERVICE) && (pending_error != '0);
  assign pop         = have_rep && (send_code == mfdq_pkg::SEND_OK);

  always_comb begin
    if (push_frame) begin
      new_entry.dx      = {frame_bytes[1], frame_bytes[0]};
      new_entry.dy      = {frame_bytes[3], frame_bytes[2]};
      new_entry.buttons = frame_bytes[4];
      new_entry.wheel   = frame_bytes[5];
      new_entry.pan     = frame_bytes[6];
      new_entry.status  = mfdq_pkg::ST_FRAME_OK | mfdq_pkg::ST_QUEUED;
    end else begin
      new_entry.dx      = move_dx;
      new_entry.dy      = move_dy;
      new_entry.buttons = '0;
      new_entry.wheel   = '0;
      new_entry.pan     = '0;
      new_entry.status  = mfdq_pkg::ST_QUEUED;
    end
  end

  always_comb begin
    pending_error_next = pending_error;
    if (accept) begin
      case (op)
        mfdq_pkg::OP_BYTE: begin
          if (frame_end && !frame_good) begin
            pending_error_next = mfdq_pkg::ST_CHECK_ERR;
          end else if (frame_end && queue_full) begin
            pending_error_next = mfdq_pkg::ST_FRAME_OK | mfdq_pkg::ST_DROPPED;
          end
        end
        mfdq_pkg::OP_LINE_ERR: pending_error_next = pending_error | mfdq_pkg::ST_OVERRUN;
        mfdq_pkg::OP_PACKET:   pending_error_next = pending_error;
        mfdq_pkg::OP_SERVICE:  pending_error_next = '0;
        default:               pending_error_next = pending_error;
      endcase
    end
  end

  // result beats of a service pass: report, status once per entry, pending error
  always_comb begin
    case (send_code)
      mfdq_pkg::SEND_OK:   send_bit = mfdq_pkg::ST_SENT;
      mfdq_pkg::SEND_BUSY: send_bit = mfdq_pkg::ST_BUSY;
      default:             send_bit = mfdq_pkg::ST_FAIL;
    endcase

    rep_res         = '0;
    rep_res.kind    = mfdq_pkg::KIND_REPORT;
    rep_res.dx      = head_entry.dx;
    rep_res.dy      = head_entry.dy;
    rep_res.buttons = head_entry.buttons;
    rep_res.wheel   = head_entry.wheel;
    rep_res.pan     = head_entry.pan;

    stat_res        = '0;
    stat_res.kind   = mfdq_pkg::KIND_STATUS;
    stat_res.status = head_entry.status | send_bit;

    err_res         = '0;
    err_res.kind    = mfdq_pkg::KIND_STATUS;
    err_res.status  = pending_error;

    push_bus          = '0;
    push_bus.n        = mfdq_pkg::NRES_W'(have_rep) + mfdq_pkg::NRES_W'(send_status) +
                        mfdq_pkg::NRES_W'(flush_err);
    push_bus.beats[0] = have_rep ? rep_res : err_res;
    push_bus.beats[1] = send_status ? stat_res : err_res;
    push_bus.beats[2] = err_res;
    for (int k = 0; k < mfdq_pkg::MAX_RESULTS; k++) begin
      push_bus.beats[k].last = (mfdq_pkg::NRES_W'(k + 1) == push_bus.n);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (op == mfdq_pkg::OP_BYTE) && in_frame &&
        (byte_position >= mfdq_pkg::FPOS_W'(2)) &&
        (byte_position < mfdq_pkg::FPOS_W'(mfdq_pkg::FRAME_LEN - 1))) begin
      frame_bytes[pidx] <= rx_byte;
    end
    if (push) begin
      queue_entries[queue_tail] <= new_entry;
    end
    if (accept && (op == mfdq_pkg::OP_BYTE)) begin
      if (!in_frame) begin
        xor_acc <= rx_byte;
      end else begin
        xor_acc <= xor_acc ^ rx_byte;
      end
      if (in_frame && (byte_position == mfdq_pkg::FPOS_W'(1))) begin
        opcode_ok <= (rx_byte == mfdq_pkg::FRAME_OPCODE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame            <= 1'b0;
      byte_position       <= '0;
      queue_head          <= '0;
      queue_tail          <= '0;
      queue_count         <= '0;
      pending_error       <= '0;
      status_already_sent <= 1'b0;
    end else begin
      pending_error <= pending_error_next;
      if (accept && (op == mfdq_pkg::OP_BYTE)) begin
        if (!in_frame) begin
          if (rx_byte == mfdq_pkg::START_BYTE) begin
            in_frame      <= 1'b1;
            byte_position <= mfdq_pkg::FPOS_W'(1);
          end
        end else if (frame_end) begin
          in_frame      <= 1'b0;
          byte_position <= '0;
        end else begin
          byte_position <= byte_position + 1'b1;
        end
      end
      if (push) begin
        queue_tail  <= (queue_tail == mfdq_pkg::QPTR_W'(mfdq_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : queue_tail + 1'b1;
        queue_count <= queue_count + 1'b1;
      end
      if (pop) begin
        queue_head  <= (queue_head == mfdq_pkg::QPTR_W'(mfdq_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : queue_head + 1'b1;
        queue_count <= queue_count - 1'b1;
      end
      if (pop) begin
        status_already_sent <= 1'b0;
      end else if (send_status) begin
        status_already_sent <= 1'b1;
      end
    end
  end

  mfdq_out_fifo u_out_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push_bus),
    .space_ok   (space_ok),
    .head       (out_res),
    .head_valid (result_valid),
    .head_ready (result_ready)
  );

  assign result_kind    = out_res.kind;
  assign report_dx      = out_res.dx;
  assign report_dy      = out_res.dy;
  assign report_buttons = out_res.buttons;
  assign report_wheel   = out_res.wheel;
  assign report_pan     = out_res.pan;
  assign status_byte    = out_res.status;
  assign last_of_run    = out_res.last;

endmodule

/* src/mfdq_out_fifo.sv */
`timescale 1ns / 1ps

module mfdq_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  mfdq_pkg::push_t   push,
  output logic              space_ok,
  output mfdq_pkg::result_t head,
  output logic              head_valid,
  input  logic              head_ready
);

  mfdq_pkg::result_t mem [mfdq_pkg::OUT_DEPTH];

  logic [mfdq_pkg::OUT_PTR_W-1:0] rd_ptr;
  logic [mfdq_pkg::OUT_PTR_W-1:0] wr_ptr;
  logic [mfdq_pkg::OUT_CNT_W-1:0] count;
  logic [mfdq_pkg::OUT_CNT_W-1:0] count_next;
  logic [mfdq_pkg::OUT_PTR_W-1:0] wr_idx [mfdq_pkg::MAX_RESULTS];
  logic                           pop;

  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign pop        = head_valid && head_ready;
  // room for the worst-case burst of one item
  assign space_ok   = count <= mfdq_pkg::OUT_CNT_W'(mfdq_pkg::OUT_DEPTH - mfdq_pkg::MAX_RESULTS);

  always_comb begin
    for (int k = 0; k < mfdq_pkg::MAX_RESULTS; k++) begin
      wr_idx[k] = wr_ptr + mfdq_pkg::OUT_PTR_W'(k);
    end
    count_next = count + mfdq_pkg::OUT_CNT_W'(push.n) - mfdq_pkg::OUT_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < mfdq_pkg::MAX_RESULTS; k++) begin
      if (mfdq_pkg::NRES_W'(k) < push.n) begin
        mem[wr_idx[k]] <= push.beats[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + mfdq_pkg::OUT_PTR_W'(push.n);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

endmodule

/* src/mfdq_checker.sv */
`timescale 1ns / 1ps

module mfdq_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_ready,
  input logic              result_valid,
  input logic              result_ready,
  input logic              result_kind,
  input logic signed [15:0] report_dx,
  input logic signed [15:0] report_dy,
  input logic [7:0]        report_buttons,
  input logic signed [7:0] report_wheel,
  input logic signed [7:0] report_pan,
  input logic [7:0]        status_byte
);

  // a stalled result beat stays offered
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result beat dropped while stalled");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_kind == mfdq_pkg::KIND_STATUS) |->
      (report_dx == '0) && (report_dy == '0) && (report_buttons == '0) &&
      (report_wheel == '0) && (report_pan == '0))
    else $error("status beat carries motion data");

  a_report_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_kind == mfdq_pkg::KIND_REPORT) |-> (status_byte == '0))
    else $error("report beat carries a status byte");

  // first cycle out of reset: nothing offered, input open
  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !result_valid && item_ready)
    else $error("result buffer not empty after reset");

endmodule

bind mouse_frame_deframer_queue mfdq_checker u_mfdq_checker (
  .clk            (clk),
  .rst            (rst),
  .item_ready     (item_ready),
  .result_valid   (result_valid),
  .result_ready   (result_ready),
  .result_kind    (result_kind),
  .report_dx      (report_dx),
  .report_dy      (report_dy),
  .report_buttons (report_buttons),
  .report_wheel   (report_wheel),
  .report_pan     (report_pan),
  .status_byte    (status_byte)
);

/* dv/tb_mouse_frame_deframer_queue.sv */
`timescale 1ns / 1ps

module tb_mouse_frame_deframer_queue;

  localparam logic [1:0] SEND_FAIL  = 2'd2;
  localparam logic [1:0] SEND_UNDEF = 2'd3;  // not a legal code, behaves as a failure
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 10;

  typedef struct {
    mfdq_pkg::op_t      op;
    logic [7:0]         rx;
    logic [6:0]         plen;
    logic [7:0]         rep;
    logic [7:0]         feat;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic               ep_ready;
    logic [1:0]         code;
  } item_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_ready;
  logic [1:0]         operation = '0;
  logic [7:0]         rx_byte = '0;
  logic [6:0]         packet_length = '0;
  logic [7:0]         report_byte = '0;
  logic [7:0]         feature_byte = '0;
  logic signed [15:0] move_dx = '0;
  logic signed [15:0] move_dy = '0;
  logic               endpoint_ready = 1'b0;
  logic [1:0]         send_code = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  logic               result_kind;
  logic signed [15:0] report_dx;
  logic signed [15:0] report_dy;
  logic [7:0]         report_buttons;
  logic signed [7:0]  report_wheel;
  logic signed [7:0]  report_pan;
  logic [7:0]         status_byte;
  logic               last_of_run;

  mouse_frame_deframer_queue uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready),
    .operation(operation), .rx_byte(rx_byte), .packet_length(packet_length),
    .report_byte(report_byte), .feature_byte(feature_byte),
    .move_dx(move_dx), .move_dy(move_dy),
    .endpoint_ready(endpoint_ready), .send_code(send_code),
    .result_valid(result_valid), .result_ready(result_ready),
    .result_kind(result_kind), .report_dx(report_dx), .report_dy(report_dy),
    .report_buttons(report_buttons), .report_wheel(report_wheel),
    .report_pan(report_pan), .status_byte(status_byte), .last_of_run(last_of_run)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // mirror of the deframer and motion queue
  logic              fr_active;
  int                fr_pos;
  logic [7:0]        fr_bytes [mfdq_pkg::FRAME_LEN];
  mfdq_pkg::entry_t  mq_entries [mfdq_pkg::QUEUE_DEPTH];
  int                mq_head, mq_tail, mq_count;
  logic [7:0]        err_pending;
  logic              head_status_sent;
  mfdq_pkg::result_t due_reports [$];

  int  mismatches = 0;
  int  items_sent = 0;
  int  cycle_count = 0;
  bit  no_idle = 1'b0;
  int  hold_len = 0;
  int  hold_req = 0;
  int  hold_ack = 0;
  int  hold_left = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic mfdq_pkg::result_t make_result(logic kind, mfdq_pkg::entry_t e,
                                                    logic [7:0] st);
    mfdq_pkg::result_t r;
    r.kind    = kind;
    r.dx      = e.dx;
    r.dy      = e.dy;
    r.buttons = e.buttons;
    r.wheel   = e.wheel;
    r.pan     = e.pan;
    r.status  = st;
    r.last    = 1'b0;
    return r;
  endfunction

  function automatic void motion_push(mfdq_pkg::entry_t e);
    mq_entries[mq_tail] = e;
    mq_tail = (mq_tail + 1) % mfdq_pkg::QUEUE_DEPTH;
    mq_count++;
  endfunction

  function automatic void take_serial_byte(logic [7:0] b);
    logic [7:0]       chk;
    mfdq_pkg::entry_t e;
    if (!fr_active) begin
      if (b == mfdq_pkg::START_BYTE) begin
        fr_bytes[0] = b;
        fr_pos = 1;
        fr_active = 1'b1;
      end
      return;
    end
    fr_bytes[fr_pos] = b;
    fr_pos++;
    if (fr_pos == mfdq_pkg::FRAME_LEN) begin
      chk = '0;
      for (int i = 0; i < mfdq_pkg::FRAME_LEN - 1; i++) chk ^= fr_bytes[i];
      if (chk == fr_bytes[mfdq_pkg::FRAME_LEN-1] && fr_bytes[1] == mfdq_pkg::FRAME_OPCODE) begin
        if (mq_count < mfdq_pkg::QUEUE_DEPTH) begin
          e.dx      = {fr_bytes[3], fr_bytes[2]};
          e.dy      = {fr_bytes[5], fr_bytes[4]};
          e.buttons = fr_bytes[6];
          e.wheel   = fr_bytes[7];
          e.pan     = fr_bytes[8];
          e.status  = mfdq_pkg::ST_FRAME_OK | mfdq_pkg::ST_QUEUED;
          motion_push(e);
        end else begin
          err_pending = mfdq_pkg::ST_FRAME_OK | mfdq_pkg::ST_DROPPED;
        end
      end else begin
        err_pending = mfdq_pkg::ST_CHECK_ERR;
      end
      fr_active = 1'b0;
      fr_pos = 0;
    end
  endfunction

  // works out the result beats caused by one accepted item
  function automatic void deframe_and_queue(item_t it);
    mfdq_pkg::result_t res [mfdq_pkg::MAX_RESULTS];
    int                n;
    mfdq_pkg::entry_t  e;
    logic [7:0]        st;
    n = 0;
    case (it.op)
      mfdq_pkg::OP_BYTE: take_serial_byte(it.rx);
      mfdq_pkg::OP_LINE_ERR: err_pending |= mfdq_pkg::ST_OVERRUN;
      mfdq_pkg::OP_PACKET: begin
        if (it.plen >= mfdq_pkg::MOVE_MIN_LEN && it.rep == mfdq_pkg::PKT_REPORT &&
            it.feat == mfdq_pkg::PKT_FEATURE && mq_count < mfdq_pkg::QUEUE_DEPTH) begin
          e = '0;
          e.dx = it.dx;
          e.dy = it.dy;
          e.status = mfdq_pkg::ST_QUEUED;
          motion_push(e);
        end
      end
      default: begin
        if (it.ep_ready && mq_count > 0) begin
          e = mq_entries[mq_head];
          res[n] = make_result(mfdq_pkg::KIND_REPORT, e, '0);
          n++;
          if (!head_status_sent) begin
            st = e.status;
            case (it.code)
              mfdq_pkg::SEND_OK:   st |= mfdq_pkg::ST_SENT;
              mfdq_pkg::SEND_BUSY: st |= mfdq_pkg::ST_BUSY;
              default:             st |= mfdq_pkg::ST_FAIL;
            endcase
            res[n] = make_result(mfdq_pkg::KIND_STATUS, '0, st);
            n++;
            head_status_sent = 1'b1;
          end
          if (it.code == mfdq_pkg::SEND_OK) begin
            mq_head = (mq_head + 1) % mfdq_pkg::QUEUE_DEPTH;
            mq_count--;
            head_status_sent = 1'b0;
          end
        end
        if (err_pending != '0) begin
          res[n] = make_result(mfdq_pkg::KIND_STATUS, '0, err_pending);
          n++;
          err_pending = '0;
        end
      end
    endcase
    if (n > 0) res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) due_reports.push_back(res[i]);
  endfunction

  // result checking
  always @(posedge clk) begin : result_check
    mfdq_pkg::result_t want;
    if (!rst && result_valid && result_ready) begin
      if (due_reports.size() == 0) begin
        report_mismatch("result beat with nothing expected, kind", int'(result_kind), -1);
      end else begin
        want = due_reports.pop_front();
        if (result_kind !== want.kind)
          report_mismatch("result_kind", int'(result_kind), int'(want.kind));
        if (report_dx !== want.dx)
          report_mismatch("report_dx", int'(report_dx), int'(want.dx));
        if (report_dy !== want.dy)
          report_mismatch("report_dy", int'(report_dy), int'(want.dy));
        if (report_buttons !== want.buttons)
          report_mismatch("report_buttons", int'(report_buttons), int'(want.buttons));
        if (report_wheel !== want.wheel)
          report_mismatch("report_wheel", int'(report_wheel), int'(want.wheel));
        if (report_pan !== want.pan)
          report_mismatch("report_pan", int'(report_pan), int'(want.pan));
        if (status_byte !== want.status)
          report_mismatch("status_byte", int'(status_byte), int'(want.status));
        if (last_of_run !== want.last)
          report_mismatch("last_of_run", int'(last_of_run), int'(want.last));
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_ack != hold_req) begin
      hold_ack <= hold_req;
      hold_left <= hold_len;
      result_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_ready <= 1'b0;
    end else begin
      result_ready <= no_idle || ($urandom_range(99) >= 14);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d beats still due", cycle_count,
               due_reports.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_item(input item_t it);
    item_valid     <= 1'b1;
    operation      <= it.op;
    rx_byte        <= it.rx;
    packet_length  <= it.plen;
    report_byte    <= it.rep;
    feature_byte   <= it.feat;
    move_dx        <= it.dx;
    move_dy        <= it.dy;
    endpoint_ready <= it.ep_ready;
    send_code      <= it.code;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    deframe_and_queue(it);
    items_sent++;
    if (!no_idle && $urandom_range(99) < 14) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // unused fields carry random junk
  function automatic item_t rand_item(mfdq_pkg::op_t op);
    item_t it;
    it.op       = op;
    it.rx       = 8'($urandom);
    it.plen     = 7'($urandom);
    it.rep      = 8'($urandom);
    it.feat     = 8'($urandom);
    it.dx       = 16'($urandom);
    it.dy       = 16'($urandom);
    it.ep_ready = 1'($urandom);
    it.code     = 2'($urandom);
    return it;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    item_t it;
    it = rand_item(mfdq_pkg::OP_BYTE);
    it.rx = b;
    send_item(it);
  endtask

  task automatic send_line_err();
    send_item(rand_item(mfdq_pkg::OP_LINE_ERR));
  endtask

  task automatic send_packet(input logic [6:0] len, input logic [7:0] rep, feat,
                             input logic [15:0] dx, dy);
    item_t it;
    it = rand_item(mfdq_pkg::OP_PACKET);
    it.plen = len;
    it.rep  = rep;
    it.feat = feat;
    it.dx   = dx;
    it.dy   = dy;
    send_item(it);
  endtask

  task automatic send_service(input logic rdy, input logic [1:0] code);
    item_t it;
    it = rand_item(mfdq_pkg::OP_SERVICE);
    it.ep_ready = rdy;
    it.code = code;
    send_item(it);
  endtask

  // err_at >= 0 slips a line error in before that frame byte
  task automatic send_frame(input logic [15:0] dx, dy, input logic [7:0] btn, whl, pan,
                            input logic [7:0] opc, chk_flip, input int err_at);
    logic [7:0] fb [mfdq_pkg::FRAME_LEN];
    logic [7:0] x;
    fb[0] = mfdq_pkg::START_BYTE;
    fb[1] = opc;
    fb[2] = dx[7:0];
    fb[3] = dx[15:8];
    fb[4] = dy[7:0];
    fb[5] = dy[15:8];
    fb[6] = btn;
    fb[7] = whl;
    fb[8] = pan;
    x = '0;
    for (int i = 0; i < mfdq_pkg::FRAME_LEN - 1; i++) x ^= fb[i];
    fb[mfdq_pkg::FRAME_LEN-1] = x ^ chk_flip;
    for (int i = 0; i < mfdq_pkg::FRAME_LEN; i++) begin
      if (i == err_at) send_line_err();
      send_byte(fb[i]);
    end
  endtask

  task automatic send_random_frame(input logic [7:0] opc, chk_flip);
    send_frame(16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
               opc, chk_flip, -1);
  endtask

  // sender stops and waits for every due beat; always lets at least one edge pass
  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (due_reports.size() != 0) @(posedge clk);
  endtask

  // one well-formed sequence most of the time, broken ones and noise otherwise
  task automatic random_sequence();
    int pick;
    pick = $urandom_range(99);
    if (pick < 24) begin
      send_random_frame(mfdq_pkg::FRAME_OPCODE, 8'h00);
    end else if (pick < 28) begin
      send_random_frame(mfdq_pkg::FRAME_OPCODE, 8'($urandom_range(1, 255)));
    end else if (pick < 30) begin
      send_random_frame(8'($urandom_range(255)), 8'h00);
    end else if (pick < 41) begin
      send_packet(7'($urandom_range(mfdq_pkg::MOVE_MIN_LEN, 64)), mfdq_pkg::PKT_REPORT,
                  mfdq_pkg::PKT_FEATURE, 16'($urandom), 16'($urandom));
    end else if (pick < 45) begin
      send_packet(7'($urandom),
                  ($urandom_range(0, 3) == 0) ? mfdq_pkg::PKT_REPORT : 8'($urandom),
                  ($urandom_range(0, 3) == 0) ? mfdq_pkg::PKT_FEATURE : 8'($urandom),
                  16'($urandom), 16'($urandom));
    end else if (pick < 84) begin
      repeat ($urandom_range(1, 3))
        send_service($urandom_range(99) < 90,
                     ($urandom_range(99) < 75) ? mfdq_pkg::SEND_OK :
                                                 2'($urandom_range(1, 3)));
    end else if (pick < 88) begin
      send_line_err();
    end else begin
      send_item(rand_item(mfdq_pkg::op_t'(2'($urandom_range(0, 3)))));
    end
  endtask

  task automatic test_directed();
    send_byte(8'h55);  // ignored while hunting
    send_frame(16'h7FFF, 16'h8000, 8'hFF, 8'h80, 8'h7F, mfdq_pkg::FRAME_OPCODE, 8'h00, 4);
    send_service(1'b1, mfdq_pkg::SEND_BUSY);  // report, status, pending overrun
    send_service(1'b1, SEND_UNDEF);           // resend, no second status
    send_service(1'b0, mfdq_pkg::SEND_OK);    // endpoint not ready
    send_service(1'b1, SEND_FAIL);
    send_service(1'b1, mfdq_pkg::SEND_OK);
    send_packet(7'd7, mfdq_pkg::PKT_REPORT, mfdq_pkg::PKT_FEATURE, 16'h8000, 16'h7FFF);
    send_packet(7'd6, mfdq_pkg::PKT_REPORT, mfdq_pkg::PKT_FEATURE, 16'h1234, 16'h5678);
    send_packet(7'd127, 8'h11, mfdq_pkg::PKT_FEATURE, 16'hFFFF, 16'h0000);
    send_packet(7'd64, mfdq_pkg::PKT_REPORT, 8'h01, 16'h0001, 16'hFFFF);
    send_service(1'b1, mfdq_pkg::SEND_OK);
    send_service(1'b1, mfdq_pkg::SEND_OK);    // queue empty
    send_frame(16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00, -1);
    send_service(1'b1, mfdq_pkg::SEND_OK);    // flushes the check error
  endtask

  // overfill the motion queue while the receiver holds off
  task automatic test_queue_pressure();
    wait_drained();
    hold_len = 250;
    hold_req++;
    repeat (mfdq_pkg::QUEUE_DEPTH + 1)
      send_packet(7'($urandom_range(mfdq_pkg::MOVE_MIN_LEN, 127)), mfdq_pkg::PKT_REPORT,
                  mfdq_pkg::PKT_FEATURE, 16'($urandom), 16'($urandom));
    send_random_frame(mfdq_pkg::FRAME_OPCODE, 8'h00);  // dropped, queue full
    repeat (mfdq_pkg::QUEUE_DEPTH + 4) send_service(1'b1, mfdq_pkg::SEND_OK);
    wait_drained();
  endtask

  task automatic test_burst_no_idle();
    int start;
    start = items_sent;
    no_idle = 1'b1;
    while (items_sent - start < 60) random_sequence();
    no_idle = 1'b0;
  endtask

  task automatic test_random_traffic();
    while (items_sent < 260) random_sequence();
  endtask

  initial begin
    fr_active = 1'b0;
    fr_pos = 0;
    mq_head = 0;
    mq_tail = 0;
    mq_count = 0;
    err_pending = '0;
    head_status_sent = 1'b0;
    rst <= 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_queue_pressure();
    test_burst_no_idle();
    test_random_traffic();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
